FILE: rtl/alu8b_pkg.sv
// alu8b_pkg: widths, function codes and the booth cell state for the 8-bit alu
// no dependencies; imported by every module of alu_8bit_booth_flags
`default_nettype none

package alu8b_pkg;

  // operand width; the accumulator holds a full product
  localparam int unsigned DataWidth = 8;
  localparam int unsigned AccWidth  = 2 * DataWidth;
  // one booth radix-2 step per cell
  localparam int unsigned NumSteps  = DataWidth;

  typedef logic [3:0] func_t;

  localparam func_t FuncAdd = 4'd1;
  localparam func_t FuncSub = 4'd2;
  localparam func_t FuncMul = 4'd3;
  localparam func_t FuncAnd = 4'd4;
  localparam func_t FuncOr  = 4'd5;
  localparam func_t FuncNot = 4'd6;
  localparam func_t FuncXor = 4'd7;
  localparam func_t FuncShr = 4'd8;
  localparam func_t FuncShl = 4'd9;

  // state handed from cell to cell; {hi, lo} is the accumulator at the end
  typedef struct packed {
    logic                 mul;  // item is a multiply and takes booth steps
    logic [DataWidth-1:0] m;    // multiplicand
    logic [DataWidth-1:0] hi;   // booth partial sum, upper result half
    logic [DataWidth-1:0] lo;   // booth multiplier, lower result half
    logic                 qn1;  // booth q(-1) bit
  } cell_t;

endpackage

`default_nettype wire

FILE: rtl/alu8b_entry.sv
// alu8b_entry: decodes the function code and forms the first cell state
// depends on alu8b_pkg; non-multiply results are finished here
`default_nettype none

module alu8b_entry (
  input  alu8b_pkg::func_t                   func_i,
  input  logic [alu8b_pkg::DataWidth-1:0]    op_a_i,
  input  logic [alu8b_pkg::DataWidth-1:0]    op_b_i,
  output alu8b_pkg::cell_t                   state_o
);
  import alu8b_pkg::*;

  logic [DataWidth-1:0] b_neg;
  logic [DataWidth-1:0] addend;
  logic [DataWidth:0]   sum;

  assign b_neg  = ~op_b_i + 1'b1;
  assign addend = (func_i == FuncSub) ? b_neg : op_b_i;
  assign sum    = {1'b0, op_a_i} + {1'b0, addend};

  always_comb begin
    state_o.mul = 1'b0;
    state_o.m   = op_a_i;
    state_o.hi  = '0;
    state_o.lo  = '0;
    state_o.qn1 = 1'b0;
    unique case (func_i)
      FuncAdd, FuncSub: begin
        state_o.hi = DataWidth'(sum[DataWidth]);
        state_o.lo = sum[DataWidth-1:0];
      end
      FuncMul: begin
        state_o.mul = 1'b1;
        state_o.lo  = op_b_i;
      end
      FuncAnd: state_o.lo = op_a_i & op_b_i;
      FuncOr:  state_o.lo = op_a_i | op_b_i;
      FuncNot: state_o.lo = ~op_a_i;
      FuncXor: state_o.lo = op_a_i ^ op_b_i;
      FuncShr: state_o.lo = {1'b0, op_a_i[DataWidth-1:1]};
      FuncShl: state_o.lo = {op_a_i[DataWidth-2:0], 1'b0};
      default: state_o.lo = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/alu8b_booth_cell.sv
// alu8b_booth_cell: one registered booth radix-2 step with its own handshake
// depends on alu8b_pkg; non-multiply items pass through unchanged
`default_nettype none

module alu8b_booth_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  alu8b_pkg::cell_t state_i,
  output logic             valid_o,
  input  logic             ready_i,
  output alu8b_pkg::cell_t state_o
);
  import alu8b_pkg::*;

  logic                 valid_q;
  cell_t                state_q, state_d;
  logic [DataWidth-1:0] psum;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    unique case ({state_i.lo[0], state_i.qn1})
      2'b10:   psum = state_i.hi - state_i.m;
      2'b01:   psum = state_i.hi + state_i.m;
      default: psum = state_i.hi;
    endcase
    state_d = state_i;
    if (state_i.mul) begin
      state_d.hi  = {psum[DataWidth-1], psum[DataWidth-1:1]};
      state_d.lo  = {psum[0], state_i.lo[DataWidth-1:1]};
      state_d.qn1 = state_i.lo[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

  // a held request keeps its state
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(state_q))
    else $error("booth cell lost a stalled request");

  // non-multiply items are not touched
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && !state_i.mul |=> state_q == $past(state_i))
    else $error("booth cell altered a non-multiply request");

  // booth step records the shifted-out multiplier bit
  a_qn1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && state_i.mul |=> state_q.qn1 == $past(state_i.lo[0]))
    else $error("booth cell q(-1) wrong");

endmodule

`default_nettype wire

FILE: rtl/alu8b_out.sv
// alu8b_out: output register with accumulator flags
// depends on alu8b_pkg; fed by the last booth cell
`default_nettype none

module alu8b_out (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  alu8b_pkg::cell_t                    state_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [alu8b_pkg::AccWidth-1:0]      acc_o,
  output logic                                zero_o,
  output logic                                carry_o,
  output logic                                sign_o,
  output logic                                ovf_o
);
  import alu8b_pkg::*;

  logic                valid_q;
  logic [AccWidth-1:0] acc_d, acc_q;
  logic                zero_q, carry_q, sign_q, ovf_q;

  assign ready_o = !valid_q || ready_i;
  assign acc_d   = {state_i.hi, state_i.lo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      acc_q   <= acc_d;
      zero_q  <= (acc_d == '0);
      carry_q <= |acc_d[AccWidth-1:DataWidth];
      sign_q  <= acc_d[DataWidth-1];
      ovf_q   <= |acc_d[AccWidth-1:DataWidth-1];
    end
  end

  assign valid_o = valid_q;
  assign acc_o   = acc_q;
  assign zero_o  = zero_q;
  assign carry_o = carry_q;
  assign sign_o  = sign_q;
  assign ovf_o   = ovf_q;

endmodule

`default_nettype wire

FILE: rtl/alu_8bit_booth_flags.sv
// alu_8bit_booth_flags: top level, 8-bit alu with booth multiply and flags
// depends on alu8b_pkg, alu8b_entry, alu8b_booth_cell, alu8b_out
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------
//   in      | in_valid_i / in_ready_o | func_i, op_a_i, op_b_i
//   out     | out_valid_o/out_ready_i | acc_o, zero/carry/sign/overflow flag
//
// one request per cycle sustained while the output is ready; each passes the
// row of booth cells, one radix-2 step per cell, then the output register
// every request walks the whole row; non-multiply results are formed on entry
// and ride along unchanged so the order is kept
// each cell has its own ready, so bubbles close up when the output stalls and
// requests keep entering until the row is full
// reset clears only valid bits; payload registers are not reset
`default_nettype none

module alu_8bit_booth_flags (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  alu8b_pkg::func_t                    func_i,
  input  logic [alu8b_pkg::DataWidth-1:0]     op_a_i,
  input  logic [alu8b_pkg::DataWidth-1:0]     op_b_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [alu8b_pkg::AccWidth-1:0]      acc_o,
  output logic                                zero_flag_o,
  output logic                                carry_flag_o,
  output logic                                sign_flag_o,
  output logic                                overflow_flag_o
);
  import alu8b_pkg::*;

  // chain links: index k feeds cell k, index NumSteps feeds the output stage
  cell_t link_state [NumSteps+1];
  logic  link_valid [NumSteps+1];
  logic  link_ready [NumSteps+1];

  // decode and non-multiply ops
  alu8b_entry u_entry (
    .func_i  (func_i),
    .op_a_i  (op_a_i),
    .op_b_i  (op_b_i),
    .state_o (link_state[0])
  );

  assign link_valid[0] = in_valid_i;
  assign in_ready_o    = link_ready[0];

  // row of booth cells, one step each
  for (genvar k = 0; k < NumSteps; k++) begin : g_cell
    alu8b_booth_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[k]),
      .ready_o (link_ready[k]),
      .state_i (link_state[k]),
      .valid_o (link_valid[k+1]),
      .ready_i (link_ready[k+1]),
      .state_o (link_state[k+1])
    );
  end

  // result register and flags
  alu8b_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (link_valid[NumSteps]),
    .ready_o (link_ready[NumSteps]),
    .state_i (link_state[NumSteps]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .acc_o   (acc_o),
    .zero_o  (zero_flag_o),
    .carry_o (carry_flag_o),
    .sign_o  (sign_flag_o),
    .ovf_o   (overflow_flag_o)
  );

  // an empty output register never blocks the input
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // carry implies overflow since 255 is above 127
  a_flag_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && carry_flag_o |-> overflow_flag_o)
    else $error("carry without overflow");

  // zero result has no other flag set
  a_zero_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_flag_o |-> !carry_flag_o && !sign_flag_o && !overflow_flag_o)
    else $error("zero result with other flags");

endmodule

`default_nettype wire
